// ===== hw/rtl/scbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scbs_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CHUNK_BYTES_DEF = 80;

  // item operations
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_WP_A,
    S_WP_D,
    S_RD_P,
    S_RD_L,
    S_RD_D,
    S_PA,
    S_PB,
    S_PL,
    S_LA,
    S_LB,
    S_CK,
    S_CA,
    S_CB,
    S_SWA,
    S_SWB,
    S_NX
  } scbs_state_t;

  typedef struct packed {
    scbs_state_t state;
    logic        accept;
  } scbs_cmd_t;

  typedef struct packed {
    logic acc_push;
    logic acc_read;
    logic acc_sort;
    logic clr_last;
    logic cmp_end;
    logic len_gt;
    logic byte_ne;
    logic byte_gt;
    logic last_pair;
    logic swapped;
  } scbs_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_ctrl
  import scbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire scbs_stat_t stat,
  output scbs_cmd_t       cmd,
  output logic            busy
);

  scbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.state  = state_r;
    cmd.accept = 1'b0;
    busy       = (state_r != S_IDLE);
    unique case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.acc_push)      state_nxt = S_WP_A;
          else if (stat.acc_read) state_nxt = S_RD_P;
          else if (stat.acc_sort) state_nxt = S_PA;
        end
      end
      S_WP_A: state_nxt = S_WP_D;
      S_WP_D: state_nxt = S_IDLE;
      S_RD_P: state_nxt = S_RD_L;
      S_RD_L: state_nxt = S_RD_D;
      S_RD_D: state_nxt = S_IDLE;
      S_PA:   state_nxt = S_PB;
      S_PB:   state_nxt = S_PL;
      S_PL:   state_nxt = S_LA;
      S_LA:   state_nxt = S_LB;
      S_LB:   state_nxt = S_CK;
      S_CK: begin
        if (stat.cmp_end) state_nxt = stat.len_gt ? S_SWA : S_NX;
        else              state_nxt = S_CA;
      end
      S_CA:   state_nxt = S_CB;
      S_CB: begin
        if (stat.byte_ne) state_nxt = stat.byte_gt ? S_SWA : S_NX;
        else              state_nxt = S_CK;
      end
      S_SWA:  state_nxt = S_SWB;
      S_SWB:  state_nxt = S_NX;
      S_NX: begin
        if (!stat.last_pair || stat.swapped) state_nxt = S_PA;
        else                                 state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scbs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_dp
  import scbs_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int LW = $clog2(CHUNK_BYTES + 1),
  localparam int BD = MAX_ENTRIES * CHUNK_BYTES,
  localparam int BW = (BD > 1) ? $clog2(BD) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scbs_cmd_t     cmd,
  output scbs_stat_t         stat,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [AW-1:0] in_entry_index,
  input  wire logic [LW-1:0] in_byte_pos,
  output logic               out_valid,
  output logic [7:0]         out_read_byte,
  output logic [LW-1:0]      out_entry_length,
  output logic [CW-1:0]      out_entry_count,
  output logic [1:0]         out_status
);

  localparam int SW = AW + 1;

  function automatic logic [BW-1:0] base_of(input logic [AW-1:0] p);
    return BW'(p) * BW'(CHUNK_BYTES);
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [AW-1:0] i);
    logic [SW-1:0] s;
    s = {1'b0, f} + {1'b0, i};
    if (s >= SW'(MAX_ENTRIES)) s = s - SW'(MAX_ENTRIES);
    return s[AW-1:0];
  endfunction

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [LW-1:0] pend_r, pend_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] wr_phys_r, wr_phys_nxt;
  logic [BW-1:0] wr_base_r, wr_base_nxt;
  logic          swapped_r, swapped_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working registers
  logic [AW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [LW-1:0] la_r, la_nxt, lb_r, lb_nxt, k_r, k_nxt;
  logic [BW-1:0] base_a_r, base_a_nxt, base_b_r, base_b_nxt;
  logic [7:0]    ba_r, ba_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic [LW-1:0] olen_r, olen_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic [1:0]    ost_r, ost_nxt;

  // memories
  logic          ptr_we;
  logic [AW-1:0] ptr_waddr, ptr_wdata, ptr_raddr, ptr_rdata;
  logic          len_we;
  logic [AW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_wdata, len_rdata;
  logic          byte_we;
  logic [BW-1:0] byte_waddr, byte_raddr;
  logic [7:0]    byte_wdata, byte_rdata;

  scbs_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_ptr_ram (
    .clk(clk), .we(ptr_we), .waddr(ptr_waddr), .wdata(ptr_wdata),
    .raddr(ptr_raddr), .rdata(ptr_rdata)
  );

  scbs_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  scbs_ram #(.WIDTH(8), .DEPTH(BD)) u_byte_ram (
    .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .raddr(byte_raddr), .rdata(byte_rdata)
  );

  logic [AW-1:0] sbf, slot_i, slot_i1;
  logic [LW-1:0] pend_inc, new_len, min_len;
  logic          full, fin, push, miss;

  assign sbf      = (front_r == '0) ? AW'(MAX_ENTRIES - 1) : front_r - 1'b1;
  assign slot_i   = slot_of(front_r, i_r);
  assign slot_i1  = slot_of(front_r, i_r + 1'b1);
  assign pend_inc = pend_r + 1'b1;
  assign full     = (count_r == CW'(MAX_ENTRIES));
  assign fin      = ((in_op == OP_CHAR) && (pend_inc == LW'(CHUNK_BYTES)))
                 || ((in_op == OP_EOL) && (pend_r != '0));
  assign push     = fin && !full;
  assign new_len  = (in_op == OP_CHAR) ? pend_inc : pend_r;
  assign miss     = (CW'(in_entry_index) >= count_r);
  assign min_len  = (la_r < lb_r) ? la_r : lb_r;

  always_comb begin
    stat.acc_push  = push;
    stat.acc_read  = (in_op == OP_READ) && !miss;
    stat.acc_sort  = (in_op == OP_SORT) && (count_r >= CW'(2));
    stat.clr_last  = (clr_r == AW'(MAX_ENTRIES - 1));
    stat.cmp_end   = (k_r == min_len);
    stat.len_gt    = (la_r > lb_r);
    stat.byte_ne   = (ba_r != byte_rdata);
    stat.byte_gt   = (ba_r > byte_rdata);
    stat.last_pair = ((CW + 1)'(i_r) + (CW + 1)'(2)) >= (CW + 1)'(count_r);
    stat.swapped   = swapped_r;
  end

  always_comb begin
    count_nxt     = count_r;
    front_nxt     = front_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    wr_phys_nxt   = wr_phys_r;
    wr_base_nxt   = wr_base_r;
    swapped_nxt   = swapped_r;
    out_valid_nxt = 1'b0;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    k_nxt         = k_r;
    base_a_nxt    = base_a_r;
    base_b_nxt    = base_b_r;
    ba_nxt        = ba_r;
    obyte_nxt     = obyte_r;
    olen_nxt      = olen_r;
    ocnt_nxt      = ocnt_r;
    ost_nxt       = ost_r;

    ptr_we     = 1'b0;
    ptr_waddr  = slot_i;
    ptr_wdata  = pb_r;
    ptr_raddr  = slot_i;
    len_we     = 1'b0;
    len_waddr  = wr_phys_r;
    len_wdata  = new_len;
    len_raddr  = pa_r;
    byte_we    = 1'b0;
    byte_waddr = wr_base_r + BW'(pend_r);
    byte_wdata = in_char_code;
    byte_raddr = base_a_r + BW'(k_r);

    unique case (cmd.state)
      S_CLR: begin
        ptr_we    = 1'b1;
        ptr_waddr = clr_r;
        ptr_wdata = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (cmd.accept) begin
          idx_nxt     = in_entry_index;
          pos_nxt     = in_byte_pos;
          i_nxt       = '0;
          swapped_nxt = 1'b0;
          obyte_nxt   = '0;
          olen_nxt    = '0;
          ocnt_nxt    = count_r;
          ost_nxt     = STAT_OK;
          case (in_op) inside
            OP_CHAR, OP_EOL: begin
              out_valid_nxt = 1'b1;
              byte_we = (in_op == OP_CHAR) && !full && (pend_r < LW'(CHUNK_BYTES));
              if (in_op == OP_CHAR) pend_nxt = pend_inc;
              if (fin) begin
                pend_nxt = '0;
                if (full) begin
                  ost_nxt = STAT_FULL;
                end else begin
                  len_we    = 1'b1;
                  front_nxt = sbf;
                  count_nxt = count_r + 1'b1;
                  ocnt_nxt  = count_r + 1'b1;
                end
              end
            end
            OP_SORT: begin
              out_valid_nxt = !stat.acc_sort;
            end
            default: begin
              if (miss) begin
                out_valid_nxt = 1'b1;
                ost_nxt       = STAT_RANGE;
              end
            end
          endcase
        end
      end
      S_WP_A: ptr_raddr = sbf;
      S_WP_D: begin
        wr_phys_nxt = ptr_rdata;
        wr_base_nxt = base_of(ptr_rdata);
      end
      S_RD_P: ptr_raddr = slot_of(front_r, idx_r);
      S_RD_L: begin
        len_raddr  = ptr_rdata;
        byte_raddr = base_of(ptr_rdata) + BW'(pos_r);
      end
      S_RD_D: begin
        out_valid_nxt = 1'b1;
        olen_nxt      = len_rdata;
        ocnt_nxt      = count_r;
        if (pos_r >= len_rdata) begin
          obyte_nxt = '0;
          ost_nxt   = STAT_RANGE;
        end else begin
          obyte_nxt = byte_rdata;
          ost_nxt   = STAT_OK;
        end
      end
      S_PA: ptr_raddr = slot_i;
      S_PB: begin
        pa_nxt    = ptr_rdata;
        ptr_raddr = slot_i1;
      end
      S_PL: begin
        pb_nxt     = ptr_rdata;
        base_a_nxt = base_of(pa_r);
        base_b_nxt = base_of(ptr_rdata);
        len_raddr  = pa_r;
      end
      S_LA: begin
        len_raddr = pb_r;
        la_nxt    = len_rdata;
      end
      S_LB: begin
        lb_nxt = len_rdata;
        k_nxt  = '0;
      end
      S_CK: byte_raddr = base_a_r + BW'(k_r);
      S_CA: begin
        ba_nxt     = byte_rdata;
        byte_raddr = base_b_r + BW'(k_r);
      end
      S_CB: begin
        if (ba_r == byte_rdata) k_nxt = k_r + 1'b1;
      end
      S_SWA: begin
        ptr_we    = 1'b1;
        ptr_waddr = slot_i;
        ptr_wdata = pb_r;
      end
      S_SWB: begin
        ptr_we      = 1'b1;
        ptr_waddr   = slot_i1;
        ptr_wdata   = pa_r;
        swapped_nxt = 1'b1;
      end
      S_NX: begin
        if (!stat.last_pair) begin
          i_nxt = i_r + 1'b1;
        end else if (swapped_r) begin
          i_nxt       = '0;
          swapped_nxt = 1'b0;
        end else begin
          out_valid_nxt = 1'b1;
          obyte_nxt     = '0;
          olen_nxt      = '0;
          ocnt_nxt      = count_r;
          ost_nxt       = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      front_r     <= '0;
      pend_r      <= '0;
      clr_r       <= '0;
      wr_phys_r   <= AW'(MAX_ENTRIES - 1);
      wr_base_r   <= BW'((MAX_ENTRIES - 1) * CHUNK_BYTES);
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      wr_phys_r   <= wr_phys_nxt;
      wr_base_r   <= wr_base_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    la_r     <= la_nxt;
    lb_r     <= lb_nxt;
    k_r      <= k_nxt;
    base_a_r <= base_a_nxt;
    base_b_r <= base_b_nxt;
    ba_r     <= ba_nxt;
    obyte_r  <= obyte_nxt;
    olen_r   <= olen_nxt;
    ocnt_r   <= ocnt_nxt;
    ost_r    <= ost_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = obyte_r;
  assign out_entry_length = olen_r;
  assign out_entry_count  = ocnt_r;
  assign out_status       = ost_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r < LW'(CHUNK_BYTES))
    else $error("pending chunk not closed at full size");

  a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
    byte_we |-> !full)
    else $error("byte stored while list full");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.state == S_SWA) |=> (cmd.state == S_SWB) && $stable(i_r))
    else $error("pointer swap split across pairs");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && push) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow the list");

endmodule

`default_nettype wire

// ===== hw/rtl/string_chunk_bubble_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// text chunker with an in-place bubble sort of the chunk list. a beat is taken
// when start is high and busy is low; every beat gives exactly one result,
// shown on the out_ ports for one cycle with out_valid high, and the receiver
// cannot stall it. after reset the block is busy while it initializes the
// slot pointer table. character and end-of-line beats are taken at one per
// cycle, except that a beat that closes a chunk into the list keeps busy high
// while it fetches the next write buffer. a read beat of a listed entry keeps
// busy high through the pointer memory lookup followed by the length/byte
// memory reads. a sort beat runs full passes until no swap happens; each
// compared pair reads both pointers and both lengths, then compares bytes one
// at a time through the single read port of the byte memory, and a swap
// writes both pointers back. swaps exchange buffer pointers, so chunk bytes
// are never copied
module string_chunk_bubble_sorter
  import scbs_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int LW = $clog2(CHUNK_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // input beat
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [AW-1:0] in_entry_index,
  input  wire logic [LW-1:0] in_byte_pos,
  // result beat
  output logic               out_valid,
  output logic [7:0]         out_read_byte,
  output logic [LW-1:0]      out_entry_length,
  output logic [CW-1:0]      out_entry_count,
  output logic [1:0]         out_status
);

  // controller sequences the ops, datapath owns list state and memories
  scbs_cmd_t  cmd;
  scbs_stat_t stat;

  scbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  scbs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_entry_index   (in_entry_index),
    .in_byte_pos      (in_byte_pos),
    .out_valid        (out_valid),
    .out_read_byte    (out_read_byte),
    .out_entry_length (out_entry_length),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

// ===== bench/string_chunk_bubble_sorter_tb.sv =====
`timescale 1ns / 1ps

module string_chunk_bubble_sorter_tb;
  import scbs_pkg::*;

  localparam int NSLOT = MAX_ENTRIES_DEF;
  localparam int CHUNK = CHUNK_BYTES_DEF;

  // one command beat plus the sender's pacing for it
  typedef struct {
    logic [1:0] op;
    logic [7:0] ch;
    logic [5:0] idx;
    logic [6:0] pos;
    int         gap_max;  // sender pauses after this beat for a random gap bounded by gap_max
    bit         drain;    // hold this beat until every result is back
  } beat_t;

  typedef struct {
    logic [7:0] rbyte;
    logic [6:0] len;
    logic [6:0] cnt;
    logic [1:0] st;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_op = OP_CHAR;
  logic [7:0] in_char_code = '0;
  logic [5:0] in_entry_index = '0;
  logic [6:0] in_byte_pos = '0;
  logic       out_valid;
  logic [7:0] out_read_byte;
  logic [6:0] out_entry_length;
  logic [6:0] out_entry_count;
  logic [1:0] out_status;

  string_chunk_bubble_sorter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_entry_index   (in_entry_index),
    .in_byte_pos      (in_byte_pos),
    .out_valid        (out_valid),
    .out_read_byte    (out_read_byte),
    .out_entry_length (out_entry_length),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the chunk list
  // ---------------------------------------------------------------------------
  logic [7:0] chunk_mem [NSLOT][CHUNK];
  logic [6:0] chunk_len [NSLOT];
  logic [6:0] list_cnt = '0;
  logic [5:0] front = '0;
  logic [6:0] fill_len = '0;

  // chunk in slot a sorts after chunk in slot b
  function automatic bit sorts_after(int a, int b);
    int n;
    n = (chunk_len[a] < chunk_len[b]) ? chunk_len[a] : chunk_len[b];
    for (int k = 0; k < n; k++)
      if (chunk_mem[a][k] != chunk_mem[b][k]) return chunk_mem[a][k] > chunk_mem[b][k];
    return chunk_len[a] > chunk_len[b];
  endfunction

  // close the chunk being collected, pushing it on the front if there is room
  function automatic logic [1:0] close_chunk();
    logic [1:0] st;
    st = STAT_OK;
    if (fill_len == 0) return st;
    if (list_cnt >= NSLOT) begin
      st = STAT_FULL;
    end else begin
      front = front - 6'd1;
      chunk_len[front] = fill_len;
      list_cnt++;
    end
    fill_len = '0;
    return st;
  endfunction

  // repeat full passes until nothing moves
  function automatic void sort_chunks();
    bit moved;
    logic [5:0] a, b;
    logic [7:0] tb;
    logic [6:0] tl;
    if (list_cnt < 2) return;
    do begin
      moved = 0;
      for (int i = 0; i + 1 < list_cnt; i++) begin
        a = front + 6'(i);
        b = front + 6'(i + 1);
        if (sorts_after(a, b)) begin
          for (int k = 0; k < CHUNK; k++) begin
            tb = chunk_mem[a][k];
            chunk_mem[a][k] = chunk_mem[b][k];
            chunk_mem[b][k] = tb;
          end
          tl = chunk_len[a];
          chunk_len[a] = chunk_len[b];
          chunk_len[b] = tl;
          moved = 1;
        end
      end
    end while (moved);
  endfunction

  function automatic result_t apply_beat(beat_t bt);
    result_t r;
    logic [5:0] s;
    r = '{rbyte: '0, len: '0, cnt: '0, st: STAT_OK};
    case (bt.op)
      OP_CHAR: begin
        // bytes land in the slot just before the front, unless the list is full
        if (list_cnt < NSLOT && fill_len < CHUNK) chunk_mem[front - 6'd1][fill_len] = bt.ch;
        fill_len++;
        if (fill_len >= CHUNK) r.st = close_chunk();
      end
      OP_EOL:  r.st = close_chunk();
      OP_SORT: sort_chunks();
      default: begin
        if (bt.idx >= list_cnt) begin
          r.st = STAT_RANGE;
        end else begin
          s = front + bt.idx;
          r.len = chunk_len[s];
          if (bt.pos >= r.len || bt.pos >= CHUNK) r.st = STAT_RANGE;
          else r.rbyte = chunk_mem[s][bt.pos];
        end
      end
    endcase
    r.cnt = list_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queue and expected results
  // ---------------------------------------------------------------------------
  beat_t   beat_q[$];
  result_t result_q[$];
  int      errors = 0;
  int      pace = 0;     // current max sender gap
  int      hold_cnt = 0;
  bit      taken = 0;

  task automatic add(logic [1:0] op, logic [7:0] ch = 0, logic [5:0] idx = 0,
                     logic [6:0] pos = 0, bit drain = 0);
    beat_q.push_back('{op: op, ch: ch, idx: idx, pos: pos, gap_max: pace, drain: drain});
  endtask

  // one line of text, of random bytes or bytes from a narrow alphabet
  task automatic add_line(int n, bit narrow);
    for (int k = 0; k < n; k++)
      add(OP_CHAR, narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom));
    add(OP_EOL);
  endtask

  task automatic add_read();
    int p;
    p = $urandom_range(0, 9);
    add(OP_READ, 8'($urandom), 6'($urandom),
        p < 7 ? 7'($urandom_range(0, 15)) : p < 9 ? 7'($urandom_range(0, 79)) : 7'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // driver: beat is taken at the rising edge, next one is set up at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      result_q.push_back(apply_beat(beat_q[0]));
      hold_cnt = $urandom_range(0, beat_q[0].gap_max);
      beat_q.pop_front();
      taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      taken = 0;
      if (hold_cnt > 0) begin
        hold_cnt--;
        start <= 1'b0;
      end else if (beat_q.size() > 0 && (!beat_q[0].drain || result_q.size() == 0)) begin
        in_op          <= beat_q[0].op;
        in_char_code   <= beat_q[0].ch;
        in_entry_index <= beat_q[0].idx;
        in_byte_pos    <= beat_q[0].pos;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_read_byte !== e.rbyte) begin
          $error("read_byte expected %0d actual %0d", e.rbyte, out_read_byte);
          errors++;
        end
        if (out_entry_length !== e.len) begin
          $error("entry_length expected %0d actual %0d", e.len, out_entry_length);
          errors++;
        end
        if (out_entry_count !== e.cnt) begin
          $error("entry_count expected %0d actual %0d", e.cnt, out_entry_count);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int sel;
    // directed: empty list, extremes, empty line, auto-closed full chunk
    pace = 0;
    add(OP_SORT);
    add(OP_READ, 8'h00, 6'd0, 7'd0);
    add(OP_EOL);
    add(OP_CHAR, 8'hff);
    add(OP_CHAR, 8'h00);
    add(OP_EOL);
    add(OP_SORT);
    add(OP_READ, 8'hff, 6'd0, 7'd1);
    add(OP_READ, 8'h00, 6'd0, 7'd2);
    add(OP_READ, 8'h00, 6'd63, 7'd127);
    add(OP_CHAR, 8'hff);
    add(OP_EOL);
    add(OP_SORT);
    add(OP_READ, 8'h00, 6'd1, 7'd0);
    add(OP_READ, 8'h00, 6'd0, 7'd79, 1);
    for (int k = 0; k < CHUNK; k++) add(OP_CHAR, 8'(k));
    add(OP_EOL);
    add(OP_READ, 8'h00, 6'd0, 7'd79);
    add(OP_READ, 8'h00, 6'd0, 7'd80);

    // random: lines until the list fills, then drops, reads and sorts
    for (int n = 0; n < 340; n++) begin
      pace = (n % 50 < 20) ? 0 : 16;
      sel = $urandom_range(0, 99);
      if (sel < 55) add_line(($urandom_range(0, 19) == 0) ? $urandom_range(70, 100)
                                                           : $urandom_range(0, 6),
                             $urandom_range(0, 1));
      else if (sel < 93) add_read();
      else if (sel < 97) add(OP_SORT);
      else add(OP_READ, 8'($urandom), 6'($urandom), 7'($urandom), 1);
    end
    add(OP_SORT);
    for (int n = 0; n < 64; n++) add(OP_READ, 8'($urandom), 6'(n), 7'($urandom_range(0, 3)));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (beat_q.size() == 0 && result_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // timeout
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== string_chunk_bubble_sorter.f =====
hw/rtl/scbs_pkg.sv
hw/rtl/scbs_ram.sv
hw/rtl/scbs_ctrl.sv
hw/rtl/scbs_dp.sv
hw/rtl/string_chunk_bubble_sorter.sv
bench/string_chunk_bubble_sorter_tb.sv
